// ----- hdl/sfr_pkg.sv -----
// Shared types and constants for the streaming find-and-replace block.
// No dependencies; every other file in hdl/ imports this package.
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int TEXT_BYTES  = 8;                      // bytes in pattern/replacement registers
  localparam int TI_W        = $clog2(TEXT_BYTES);     // byte index within those registers
  localparam int CFG_W       = BYTE_W * TEXT_BYTES;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = $clog2(TEXT_BYTES + 1); // counts 0..TEXT_BYTES
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = QA_W + 1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    CFG_MATCH_PATTERN      = 2'd0,
    CFG_MATCH_LENGTH       = 2'd1,
    CFG_REPLACEMENT_TEXT   = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_index_t;

  // Pattern or replacement register pair
  typedef struct packed {
    logic [CFG_W-1:0] text;
    logic [LEN_W-1:0] length;
  } sfr_text_cfg_t;

  // One classified request from the front end to the emitter
  typedef struct packed {
    byte_t [TEXT_BYTES-1:0] win;        // window bytes, oldest first
    logic [CNT_W-1:0]       emit_count; // window bytes to release verbatim
    logic                   matched;    // follow them with the replacement
    logic                   last;       // final request of the text
  } sfr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sfr_queue_status_t;

endpackage

// ----- hdl/sfr_stream_if.sv -----
// Valid/ready stream interfaces for the text input and output channels.
// Depends on sfr_pkg.
interface sfr_in_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_has_byte;
  logic  out_last;

  modport source (output valid, out_byte, out_has_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_has_byte, out_last, output ready);
endinterface

// ----- hdl/sfr_front.sv -----
// Front end: accepts text bytes, tracks held pattern-prefix bytes and
// classifies each byte into an emit request. Depends on sfr_pkg, sfr_stream_if.
module sfr_front import sfr_pkg::*; #(
  parameter int MATCH_MAX = 8
) (
  input  logic              clk,
  input  logic              rst,
  sfr_in_if.sink            text_in,
  input  sfr_text_cfg_t     find_cfg,
  input  logic              held_clear,
  input  sfr_queue_status_t q_status,
  output logic              push,
  output sfr_cmd_t          cmd
);

  localparam int W  = MATCH_MAX;
  localparam int CW = $clog2(W + 1);

  byte_t          held_bytes [W];
  logic [CW-1:0]  held_count;

  logic [CW-1:0]  plen;
  logic [CW-1:0]  n;
  logic [CW-1:0]  sel;
  logic [CW-1:0]  rem;
  logic           matched;
  logic           accept;
  byte_t          win     [W];
  byte_t          shifted [W];
  logic [W-1:0]   ok;
  logic [W-1:0]   full;

  // Saturate pattern length and build the window: held bytes then the new byte
  always_comb begin
    plen = (find_cfg.length > LEN_W'(W)) ? CW'(W) : find_cfg.length[CW-1:0];
    n    = held_count + CW'(1);
    for (int i = 0; i < W; i++) begin
      win[i] = (CW'(i) < held_count) ? held_bytes[i] : text_in.in_byte;
    end
  end

  // Test every window suffix against the pattern head
  always_comb begin
    for (int s = 0; s < W; s++) begin
      ok[s] = (CW'(s) < n) && (n - CW'(s) <= plen) && (plen != '0);
      for (int i = 0; i < W - s; i++) begin
        if ((CW'(s + i) < n) && (win[s+i] != find_cfg.text[BYTE_W*i +: BYTE_W])) begin
          ok[s] = 1'b0;
        end
      end
      full[s] = ok[s] && (n - CW'(s) == plen);
    end
  end

  // Pick the longest suffix that is still a prefix
  always_comb begin
    sel     = n;
    matched = 1'b0;
    for (int s = W - 1; s >= 0; s--) begin
      if (ok[s]) begin
        sel     = CW'(s);
        matched = full[s];
      end
    end
    rem = n - sel;
  end

  // Realign the kept suffix to the start of the hold buffer
  always_comb begin
    for (int i = 0; i < W; i++) begin
      shifted[i] = win[i];
      for (int j = i; j < W; j++) begin
        if (sel == CW'(j - i)) begin
          shifted[i] = win[j];
        end
      end
    end
  end

  // Form the request for the emitter
  always_comb begin
    cmd.win = '0;
    for (int i = 0; i < W; i++) begin
      cmd.win[i] = win[i];
    end
    cmd.emit_count = (text_in.in_last && !matched) ? CNT_W'(n) : CNT_W'(sel);
    cmd.matched    = matched;
    cmd.last       = text_in.in_last;
  end

  assign text_in.ready = !q_status.full;
  assign accept        = text_in.valid && text_in.ready;
  assign push          = accept && ((cmd.emit_count != '0) || matched || text_in.in_last);

  // Hold count: drop on match, end of text or pattern or length rewrite
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (held_clear) begin
      held_count <= '0;
    end else if (accept) begin
      if (matched || text_in.in_last) begin
        held_count <= '0;
      end else begin
        held_count <= rem;
      end
    end
  end

  // Hold buffer bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < W; i++) begin
        held_bytes[i] <= shifted[i];
      end
    end
  end

  a_held_below_max: assert property (@(posedge clk) disable iff (rst)
    held_count < CW'(W))
    else $error("held byte count reached the pattern maximum");

endmodule

// ----- hdl/sfr_queue.sv -----
// Short request queue between the front end and the emitter.
// Depends on sfr_pkg.
module sfr_queue import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfr_cmd_t          push_cmd,
  input  logic              pop,
  output sfr_cmd_t          head,
  output sfr_queue_status_t status
);

  sfr_cmd_t         mem [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;

  assign status.full  = (count == QC_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      if (push && !pop) begin
        count <= count + QC_W'(1);
      end else if (pop && !push) begin
        count <= count - QC_W'(1);
      end
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("request popped from an empty queue");

endmodule

// ----- hdl/sfr_back.sv -----
// Emitter: walks each queued request one byte per unstalled cycle into
// a registered output stage. Depends on sfr_pkg, sfr_stream_if.
module sfr_back import sfr_pkg::*; #(
  parameter int REPLACE_MAX = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  sfr_cmd_t          cmd,
  input  sfr_queue_status_t q_status,
  output logic              pop,
  input  sfr_text_cfg_t     rep_cfg,
  sfr_out_if.source         text_out
);

  localparam int PW = $clog2(TEXT_BYTES + REPLACE_MAX + 1);
  localparam int RW = $clog2(REPLACE_MAX + 1);

  logic [PW-1:0] pos;
  logic [RW-1:0] rlen;
  logic [PW-1:0] total;
  logic [PW-1:0] ridx;
  logic          at_end;
  logic          advance;
  byte_t         cur_byte;

  // Size the request and pick the byte at the current position
  always_comb begin
    rlen   = (rep_cfg.length > LEN_W'(REPLACE_MAX)) ? RW'(REPLACE_MAX)
                                                    : rep_cfg.length[RW-1:0];
    total  = PW'(cmd.emit_count) + (cmd.matched ? PW'(rlen) : '0);
    at_end = (pos == total - PW'(1));
    ridx   = pos - PW'(cmd.emit_count);
    if (pos < PW'(cmd.emit_count)) begin
      cur_byte = cmd.win[pos[TI_W-1:0]];
    end else begin
      cur_byte = rep_cfg.text[BYTE_W*ridx[TI_W-1:0] +: BYTE_W];
    end
  end

  assign advance = !text_out.valid || text_out.ready;
  assign pop     = advance && !q_status.empty && ((total == '0) || at_end);

  // Output valid and position within the request
  always_ff @(posedge clk) begin
    if (rst) begin
      text_out.valid <= 1'b0;
      pos            <= '0;
    end else if (advance) begin
      if (!q_status.empty) begin
        if (total == '0) begin
          text_out.valid <= cmd.last;
          pos            <= '0;
        end else begin
          text_out.valid <= 1'b1;
          pos            <= at_end ? '0 : pos + PW'(1);
        end
      end else begin
        text_out.valid <= 1'b0;
      end
    end
  end

  // Output payload; an empty final request gives a bare end marker
  always_ff @(posedge clk) begin
    if (advance && !q_status.empty) begin
      text_out.out_byte     <= (total == '0) ? '0 : cur_byte;
      text_out.out_has_byte <= (total != '0);
      text_out.out_last     <= cmd.last && ((total == '0) || at_end);
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (!q_status.empty && total != '0) |-> pos < total)
    else $error("emit position ran past the request");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (text_out.valid && !text_out.out_has_byte) |-> text_out.out_last)
    else $error("bare end marker without last flag");

endmodule

// ----- hdl/stream_find_replace.sv -----
// Streaming find-and-replace-all on a byte stream.
// Depends on sfr_pkg, sfr_stream_if, sfr_front, sfr_queue, sfr_back.
//
// text_in carries one text byte per request with in_last on the final byte.
// text_out carries one result per request: a byte with out_has_byte set, or
// a bare end marker (out_has_byte 0) when the final byte produces nothing;
// out_last flags the final result of the text.
// The config port writes the pattern (index 0), pattern length (1),
// replacement (2) and replacement length (3) with cfg_we; writes to the
// pattern or its length drop any held bytes. Write only while idle.
// Throughput: the front end takes one byte per cycle while the 4-entry
// request queue has room; the emitter sends one result per cycle while
// text_out is not stalled, a held byte costs the output nothing, and a
// match that emits nothing occupies the emitter without sending a result.
// The emitter's single output register sets the sustained rate.
// From the edge that accepts it, the first result of a byte passes through
// the request queue and the output register, when both are empty.
// Reset clears the hold count, the queue, the output valid flag and all
// configuration (pattern length 0: bytes pass through). When text_out is
// stalled the output holds, the queue fills, then text_in.ready drops.
module stream_find_replace import sfr_pkg::*; #(
  parameter int MATCH_MAX   = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  sfr_in_if.sink           text_in,
  sfr_out_if.source        text_out
);

  sfr_text_cfg_t     find_cfg;
  sfr_text_cfg_t     rep_cfg;
  sfr_queue_status_t q_status;
  sfr_cmd_t          push_cmd;
  sfr_cmd_t          head_cmd;
  logic              push;
  logic              pop;
  logic              held_clear;

  assign held_clear = cfg_we &&
                      ((cfg_index == CFG_MATCH_PATTERN) || (cfg_index == CFG_MATCH_LENGTH));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      find_cfg <= '0;
      rep_cfg  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_PATTERN:      find_cfg.text   <= cfg_data;
        CFG_MATCH_LENGTH:       find_cfg.length <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_TEXT:   rep_cfg.text    <= cfg_data;
        CFG_REPLACEMENT_LENGTH: rep_cfg.length  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfr_front #(
    .MATCH_MAX (MATCH_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .find_cfg   (find_cfg),
    .held_clear (held_clear),
    .q_status   (q_status),
    .push       (push),
    .cmd        (push_cmd)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .status   (q_status)
  );

  sfr_back #(
    .REPLACE_MAX (REPLACE_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .q_status (q_status),
    .pop      (pop),
    .rep_cfg  (rep_cfg),
    .text_out (text_out)
  );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for stream_find_replace: directed and random texts,
// results predicted in the bench and compared one by one against the output.
// Depends on sfr_pkg and sfr_stream_if from hdl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int MATCH_MAX    = 8;
  localparam int REPLACE_MAX  = 8;
  localparam int RANDOM_ITEMS = 210;
  localparam int IDLE_CYCLES  = 8;

  typedef struct packed {
    byte_t data;
    logic  has_byte;
    logic  last;
  } text_result_t;

  typedef enum int {
    RX_FULL,
    RX_COIN,
    RX_MOSTLY,
    RX_BURSTY
  } rx_mode_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sfr_in_if  text_in();
  sfr_out_if text_out();

  stream_find_replace #(
    .MATCH_MAX  (MATCH_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .text_in  (text_in),
    .text_out (text_out)
  );

  // Bench copy of the configuration and the held prefix
  logic [CFG_W-1:0] pat_text;
  int               pat_len;
  logic [CFG_W-1:0] rep_text;
  int               rep_len;
  byte_t            held_text [8];
  int               held_cnt;

  text_result_t text_expected [$];
  int           mismatches;
  int           bytes_sent;
  int           burst_left;
  rx_mode_t     rx_mode = RX_FULL;
  int           rx_left = 0;

  always #5 clk = ~clk;

  // Work out the results of one text byte and queue them
  function automatic void predict_step(input byte_t value, input logic is_last);
    byte_t        win [9];
    text_result_t step_q [$];
    int           n;
    int           s;
    int           seg;
    int           plen;
    int           rlen;
    bit           prefix;
    bit           matched;
    n       = 0;
    s       = 0;
    matched = 1'b0;
    plen    = (pat_len > MATCH_MAX) ? MATCH_MAX : pat_len;
    rlen    = (rep_len > REPLACE_MAX) ? REPLACE_MAX : rep_len;
    for (int i = 0; i < held_cnt; i++) begin
      win[n] = held_text[i];
      n++;
    end
    win[n] = value;
    n++;
    if (plen == 0) begin
      for (int i = 0; i < n; i++) step_q.push_back('{win[i], 1'b1, 1'b0});
      s = n;
    end else begin
      // release the oldest bytes until the rest is a pattern prefix
      while (s < n) begin
        seg    = n - s;
        prefix = (seg <= plen);
        for (int i = 0; prefix && i < seg; i++) begin
          if (win[s+i] != pat_text[8*i +: 8]) prefix = 1'b0;
        end
        if (prefix) begin
          if (seg == plen) begin
            matched = 1'b1;
            s       = n;
          end
          break;
        end
        step_q.push_back('{win[s], 1'b1, 1'b0});
        s++;
      end
    end
    if (matched) begin
      for (int i = 0; i < rlen; i++) step_q.push_back('{rep_text[8*i +: 8], 1'b1, 1'b0});
      held_cnt = 0;
    end else begin
      held_cnt = n - s;
      for (int i = 0; i < held_cnt; i++) held_text[i] = win[s+i];
    end
    // flush on the final byte; a text that ends in nothing gets a bare marker
    if (is_last) begin
      for (int i = 0; i < held_cnt; i++) step_q.push_back('{held_text[i], 1'b1, 1'b0});
      held_cnt = 0;
      if (step_q.size() == 0) step_q.push_back('{8'h00, 1'b0, 1'b1});
      else step_q[step_q.size()-1].last = 1'b1;
    end
    foreach (step_q[i]) text_expected.push_back(step_q[i]);
  endfunction

  // Drive one request and wait for its handshake, then maybe pause
  task automatic send_byte(input byte_t value, input logic is_last);
    int gap;
    text_in.valid   <= 1'b1;
    text_in.in_byte <= value;
    text_in.in_last <= is_last;
    do @(posedge clk); while (text_in.ready !== 1'b1);
    predict_step(value, is_last);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      text_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  task automatic wait_idle();
    text_in.valid <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it; the caller lowers cfg_we
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_MATCH_PATTERN: begin
        pat_text = value;
        held_cnt = 0;
      end
      CFG_MATCH_LENGTH: begin
        pat_len  = int'(value[LEN_W-1:0]);
        held_cnt = 0;
      end
      CFG_REPLACEMENT_TEXT: begin
        rep_text = value;
      end
      CFG_REPLACEMENT_LENGTH: begin
        rep_len = int'(value[LEN_W-1:0]);
      end
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] pat, input int plen,
                           input logic [CFG_W-1:0] rep, input int rlen);
    write_reg(CFG_MATCH_PATTERN, pat);
    write_reg(CFG_MATCH_LENGTH, CFG_W'(plen));
    write_reg(CFG_REPLACEMENT_TEXT, rep);
    write_reg(CFG_REPLACEMENT_LENGTH, CFG_W'(rlen));
    cfg_we <= 1'b0;
  endtask

  task automatic send_text(input byte_t text_q [$]);
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Reset configuration: pattern length 0, every byte passes through
  task automatic test_reset_pass_through();
    send_text('{8'h00, 8'hFF, 8'hA5, 8'h5A});
    wait_idle();
  endtask

  // Length registers above eight act as eight
  task automatic test_saturated_lengths();
    configure(64'hEF10_FE7F_8001_FF00, 15, 64'h0123_4567_89AB_CDEF, 12);
    send_text('{8'h33, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10, 8'hEF});
    wait_idle();
  endtask

  // Empty replacement, including a final byte that completes a match
  task automatic test_empty_replacement();
    configure(64'h4241, 2, 64'h0, 0);
    send_text('{8'h41, 8'h42});
    send_text('{8'h41, 8'h41, 8'h42, 8'h43, 8'h41});
    wait_idle();
  endtask

  // Replacement writes keep a held prefix, pattern writes drop it
  task automatic test_pattern_rewrite();
    configure(64'h4241, 2, 64'h7A79_78, 3);
    send_byte(8'h41, 1'b0);
    wait_idle();
    write_reg(CFG_REPLACEMENT_LENGTH, CFG_W'(1));
    cfg_we <= 1'b0;
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    wait_idle();
    write_reg(CFG_MATCH_PATTERN, 64'h4241);
    cfg_we <= 1'b0;
    send_byte(8'h43, 1'b1);
    wait_idle();
  endtask

  // Texts built mostly from pattern pieces over a small alphabet
  task automatic test_random_texts();
    int               start;
    int               phase;
    int               pl;
    int               rl;
    int               plen_eff;
    int               want_len;
    int               pick;
    int               cut;
    byte_t            alpha [3];
    byte_t            text_q [$];
    logic [CFG_W-1:0] pat;
    logic [CFG_W-1:0] rep;
    start = bytes_sent;
    phase = 0;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      case (phase)
        0: begin pl = 8;  rl = 0;  end
        1: begin pl = 1;  rl = 8;  end
        2: begin pl = 0;  rl = $urandom_range(0, 8); end
        3: begin pl = 15; rl = 15; end
        default: begin
          pl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
          rl = $urandom_range(0, 15);
        end
      endcase
      alpha[0] = byte_t'($urandom);
      alpha[1] = byte_t'($urandom);
      alpha[2] = phase[0] ? 8'hFF : 8'h00;
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
      rep = {$urandom, $urandom};
      configure(pat, pl, rep, rl);
      plen_eff = (pl > MATCH_MAX) ? MATCH_MAX : pl;
      repeat ($urandom_range(2, 4)) begin
        text_q.delete();
        want_len = $urandom_range(1, 30);
        while (text_q.size() < want_len) begin
          pick = $urandom_range(0, 9);
          if (plen_eff > 0 && pick < 4) begin
            for (int i = 0; i < plen_eff; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (plen_eff > 1 && pick < 7) begin
            cut = $urandom_range(1, plen_eff - 1);
            for (int i = 0; i < cut; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (pick < 9) begin
            text_q.push_back(alpha[$urandom_range(0, 2)]);
          end else begin
            text_q.push_back(byte_t'($urandom));
          end
        end
        send_text(text_q);
      end
      phase++;
    end
    wait_idle();
  endtask

  // Receiver: switch between random stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_FULL:   text_out.ready <= 1'b1;
      RX_COIN:   text_out.ready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: text_out.ready <= ($urandom_range(0, 7) != 0);
      RX_BURSTY: text_out.ready <= ((rx_left % 12) >= 8);
      default:   text_out.ready <= 1'b1;
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    text_result_t got;
    text_result_t want;
    if (!rst && text_out.valid === 1'b1 && text_out.ready === 1'b1) begin
      got = '{text_out.out_byte, text_out.out_has_byte, text_out.out_last};
      if (text_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %h has_byte %b last %b",
                   got.data, got.has_byte, got.last);
      end else begin
        want = text_expected.pop_front();
        if (got.data !== want.data || got.has_byte !== want.has_byte ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b (byte/has_byte/last)",
                     want.data, want.has_byte, want.last,
                     got.data, got.has_byte, got.last);
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MATCH_PATTERN;
    cfg_data        = '0;
    text_in.valid   = 1'b0;
    text_in.in_byte = '0;
    text_in.in_last = 1'b0;
    pat_text        = '0;
    pat_len         = 0;
    rep_text        = '0;
    rep_len         = 0;
    held_cnt        = 0;
    mismatches      = 0;
    bytes_sent      = 0;
    burst_left      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_pass_through();
    test_saturated_lengths();
    test_empty_replacement();
    test_pattern_rewrite();
    test_random_texts();
    if (text_expected.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
